>>> rtl/core/csdm_pkg.sv
// Package: constants and arctangent table for the concentric disk mapping.
package csdm_pkg;
  localparam int ATAN_LEN  = 24;
  localparam int ATAN_BITS = 24;
  localparam logic [29:0] CORDIC_GAIN = 30'd652032874;

  function automatic logic [24:0] atan_entry(input logic [4:0] i);
    logic [24:0] t;
    unique case (i)
      5'd0: t = 25'd16777216;
      5'd1: t = 25'd9904169;
      5'd2: t = 25'd5233091;
      5'd3: t = 25'd2656399;
      5'd4: t = 25'd1333354;
      5'd5: t = 25'd667327;
      5'd6: t = 25'd333745;
      5'd7: t = 25'd166883;
      5'd8: t = 25'd83443;
      5'd9: t = 25'd41721;
      5'd10: t = 25'd20861;
      5'd11: t = 25'd10430;
      5'd12: t = 25'd5215;
      5'd13: t = 25'd2608;
      5'd14: t = 25'd1304;
      5'd15: t = 25'd652;
      5'd16: t = 25'd326;
      5'd17: t = 25'd163;
      5'd18: t = 25'd81;
      5'd19: t = 25'd41;
      5'd20: t = 25'd20;
      5'd21: t = 25'd10;
      5'd22: t = 25'd5;
      5'd23: t = 25'd3;
      default: t = 25'd0;
    endcase
    return t;
  endfunction
endpackage

>>> rtl/core/concentric_square_to_disk_map.sv
// Top level: pipelined concentric square-to-disk mapping.
// Stages: stage 0, the restoring divider (one quotient bit per stage), the
// phi stage, the CORDIC (one rotation per stage) and the output register.
// Throughput: one word per cycle; the whole pipe advances when the output
// register is empty or being drained, otherwise it holds.
// Reset: rst (synchronous, active high) clears all valid bits only.
module concentric_square_to_disk_map
  import csdm_pkg::*;
#(
  parameter int FRAC_BITS        = 16,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] u_coord, [31:16] v_coord
  input  logic        s_tlast,   // last_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] disk_x, [31:16] disk_y
  output logic        m_tlast    // last_out
);
  localparam int NIT = (ANGLE_ITERATIONS < ATAN_LEN) ? ANGLE_ITERATIONS : ATAN_LEN;
  localparam int PW  = FRAC_BITS + 5;       // phi and z width, signed
  localparam int DW  = FRAC_BITS + 18;      // divider remainder width
  localparam int SH  = ATAN_BITS - FRAC_BITS;
  localparam int XW  = 34;                  // CORDIC x,y signed Q30 plus growth

  // Whole pipe stalls only when the output register holds an untaken word.
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Stage 0: recentre, pick sector, numerator and denominator magnitudes.
  logic               v0, l0;
  logic [16:0]        num0, den0, r0;   // r0 magnitude (always >= 0)
  logic [1:0]         sec0;             // 0:b/a 1:2-a/b 2:4+b/a 3:6-a/b
  logic               neg0, zero0;
  logic signed [17:0] a_c, b_c;
  logic [1:0]         sec_c;
  logic               zero_c;

  always_comb begin
    a_c = 18'(signed'({2'b0, s_tdata[15:0]})) * 18'sd2 - 18'sd65536;
    b_c = 18'(signed'({2'b0, s_tdata[31:16]})) * 18'sd2 - 18'sd65536;
    zero_c = 1'b0;
    if (a_c > -b_c) begin
      sec_c = (a_c > b_c) ? 2'd0 : 2'd1;
    end else begin
      sec_c = (a_c < b_c) ? 2'd2 : 2'd3;
      zero_c = !(a_c < b_c) && (b_c == 18'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= s_tvalid;
    if (adv) begin
      l0    <= s_tlast;
      sec0  <= sec_c;
      zero0 <= zero_c;
      unique case (sec_c)
        2'd0, 2'd2: begin
          num0 <= 17'(b_c[17] ? -b_c : b_c);
          den0 <= 17'(a_c[17] ? -a_c : a_c);
          neg0 <= b_c[17] != a_c[17];
        end
        default: begin
          num0 <= 17'(a_c[17] ? -a_c : a_c);
          den0 <= 17'(b_c[17] ? -b_c : b_c);
          neg0 <= a_c[17] != b_c[17];
        end
      endcase
      unique case (sec_c)
        2'd0: r0 <= 17'(a_c);
        2'd1: r0 <= 17'(b_c);
        2'd2: r0 <= 17'(-a_c);
        default: r0 <= 17'(-b_c);
      endcase
    end
  end

  // Divider: restoring, one quotient bit per stage, FRAC_BITS+1 bits.
  localparam int QB = FRAC_BITS + 1;
  logic          dv [QB+1];
  logic          dl [QB+1];
  logic [DW-1:0] drem [QB+1];
  logic [16:0]   dden [QB+1];
  logic [QB-1:0] dq [QB+1];
  logic [16:0]   dr [QB+1];
  logic [1:0]    dsec [QB+1];
  logic          dneg [QB+1];
  logic          dzero [QB+1];

  // Dividend is the numerator scaled up by the fraction bits.
  always_comb begin
    dv[0] = v0; dl[0] = l0; drem[0] = DW'(num0) << FRAC_BITS; dden[0] = den0;
    dq[0] = '0; dr[0] = r0; dsec[0] = sec0; dneg[0] = neg0; dzero[0] = zero0;
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [DW-1:0] sh_den;
    logic          ge;
    assign sh_den = DW'(dden[k]) << (QB - 1 - k);
    assign ge     = drem[k] >= sh_den;
    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (adv) dv[k+1] <= dv[k];
      if (adv) begin
        dl[k+1]    <= dl[k];
        drem[k+1]  <= ge ? drem[k] - sh_den : drem[k];
        dden[k+1]  <= dden[k];
        dq[k+1]    <= {dq[k][QB-2:0], ge};
        dr[k+1]    <= dr[k];
        dsec[k+1]  <= dsec[k];
        dneg[k+1]  <= dneg[k];
        dzero[k+1] <= dzero[k];
      end
    end
  end

  // Phi, quadrant and CORDIC start value.
  logic                 pv, pl;
  logic signed [PW-1:0] pz;
  logic [1:0]           pquad;
  logic signed [XW-1:0] px;
  logic signed [PW-1:0] rat_c, phi_c, ph1_c;
  logic [PW-1:0]        qraw_c;
  logic signed [PW-1:0] one_c;
  logic [47:0]          gx_c;

  always_comb begin
    one_c  = PW'(1) <<< FRAC_BITS;
    rat_c  = dzero[QB] ? '0 : PW'(dq[QB]);
    if (dneg[QB]) rat_c = -rat_c;
    unique case (dsec[QB])
      2'd0: phi_c = rat_c;
      2'd1: phi_c = (one_c <<< 1) - rat_c;
      2'd2: phi_c = (one_c <<< 2) + rat_c;
      default: phi_c = dzero[QB] ? '0 : PW'(6) * one_c - rat_c;
    endcase
    ph1_c  = phi_c + one_c;
    qraw_c = PW'(ph1_c) >> (FRAC_BITS + 1);
    gx_c   = 48'(dr[QB]) * 48'(CORDIC_GAIN);
  end

  always_ff @(posedge clk) begin
    if (rst) pv <= 1'b0;
    else if (adv) pv <= dv[QB];
    if (adv) begin
      pl    <= dl[QB];
      pz    <= phi_c - ((qraw_c << 1) <<< FRAC_BITS);
      pquad <= qraw_c[1:0];
      px    <= XW'(gx_c >> 16);
    end
  end

  // CORDIC rotation, one step per stage.
  logic                 cv [NIT+1];
  logic                 cl [NIT+1];
  logic signed [XW-1:0] cx [NIT+1];
  logic signed [XW-1:0] cy [NIT+1];
  logic signed [PW-1:0] cz [NIT+1];
  logic [1:0]           cq [NIT+1];

  always_comb begin
    cv[0] = pv; cl[0] = pl; cx[0] = px; cy[0] = '0; cz[0] = pz; cq[0] = pquad;
  end

  for (genvar i = 0; i < NIT; i++) begin : g_cordic
    logic [24:0]          t_raw;
    logic signed [PW-1:0] step;
    assign t_raw = atan_entry(5'(i));
    if (SH > 0) begin : g_rnd
      assign step = PW'((t_raw + 25'(1 << (SH - 1))) >> SH);
    end else begin : g_shl
      assign step = PW'(t_raw) <<< (-SH);
    end
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else if (adv) cv[i+1] <= cv[i];
      if (adv) begin
        cl[i+1] <= cl[i];
        cq[i+1] <= cq[i];
        if (!cz[i][PW-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - step;
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + step;
        end
      end
    end
  end

  // Quadrant fix-up, rounding and saturation into the output register.
  function automatic logic [15:0] to_q15(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] o;
    o = (v + XW'(1 << 14)) >>> 15;
    if (o > XW'(32767)) return 16'h7fff;
    if (o < -XW'(32768)) return 16'h8000;
    return o[15:0];
  endfunction

  logic signed [XW-1:0] fx_c, fy_c;
  always_comb begin
    unique case (cq[NIT])
      2'd1: begin fx_c = -cy[NIT]; fy_c = cx[NIT]; end
      2'd2: begin fx_c = -cx[NIT]; fy_c = -cy[NIT]; end
      2'd3: begin fx_c = cy[NIT]; fy_c = -cx[NIT]; end
      default: begin fx_c = cx[NIT]; fy_c = cy[NIT]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= cv[NIT];
    if (adv) begin
      m_tdata <= {to_q15(fy_c), to_q15(fx_c)};
      m_tlast <= cl[NIT];
    end
  end
endmodule

>>> tb/concentric_square_to_disk_map_tb.sv
// Testbench for the concentric square-to-disk mapping: stream driver, monitor and predictor.
`timescale 1ns / 1ps

module concentric_square_to_disk_map_tb;
  import csdm_pkg::*;

  localparam int FRAC_BITS        = 16;
  localparam int ANGLE_ITERATIONS = 16;
  // pipe depth: stage 0, divider stages, phi stage, CORDIC stages, output register
  localparam int PIPE_DEPTH = 2 + FRAC_BITS + 1 + ANGLE_ITERATIONS + 1;

  typedef struct packed {
    logic [15:0] v_coord;
    logic [15:0] u_coord;
    logic        last_sample;
  } sample_t;

  typedef struct packed {
    logic [15:0] disk_x;
    logic [15:0] disk_y;
    logic        last_out;
  } disk_pt_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [15:0] u_coord, [31:16] v_coord
  logic        s_tlast;   // last_sample
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [15:0] disk_x, [31:16] disk_y
  logic        m_tlast;   // last_out

  sample_t  pending_samples[$];
  disk_pt_t expected_points[$];
  int       mismatch_count;
  bit       stim_done;
  bit       quiet_phase;
  bit       in_taken;

  concentric_square_to_disk_map #(
    .FRAC_BITS       (FRAC_BITS),
    .ANGLE_ITERATIONS(ANGLE_ITERATIONS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor division by 2^s for signed values
  function automatic longint shift_floor(longint v, int s);
    return v >>> s;
  endfunction

  // n/d with FRAC_BITS fraction bits, truncated toward zero
  function automatic longint octant_ratio(longint n, longint d);
    longint un;
    longint ud;
    longint mag;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    if (ud == 0) return 0;
    mag = (un << FRAC_BITS) / ud;
    return ((n < 0) != (d < 0)) ? -mag : mag;
  endfunction

  function automatic longint atan_step(int i);
    longint t;
    int sh;
    t  = longint'(atan_entry(5'(i % ATAN_LEN)));
    sh = ATAN_BITS - FRAC_BITS;
    if (sh == 0) return t;
    return (t + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic logic [15:0] round_sat_q15(longint v);
    longint o;
    o = shift_floor(v + (longint'(1) << 14), 15);
    if (o > 32767) o = 32767;
    if (o < -32768) o = -32768;
    return o[15:0];
  endfunction

  // Map one square sample to the disk: sector pick, quadrant fold, CORDIC, unfold.
  function automatic disk_pt_t map_to_disk(sample_t s);
    longint one;
    longint a, b, r, phi, z, x, y, nx, ny, dx, dy;
    longint quad;
    disk_pt_t p;
    one = longint'(1) << FRAC_BITS;
    a = 2 * longint'(s.u_coord) - 65536;
    b = 2 * longint'(s.v_coord) - 65536;
    if (a > -b) begin
      if (a > b) begin
        r = a; phi = octant_ratio(b, a);
      end else begin
        r = b; phi = 2 * one - octant_ratio(a, b);
      end
    end else if (a < b) begin
      r = -a; phi = 4 * one + octant_ratio(b, a);
    end else if (b != 0) begin
      r = -b; phi = 6 * one - octant_ratio(a, b);
    end else begin
      // centre: angle forced to zero
      r = 0; phi = 0;
    end
    // phi + one is never negative here, so the arithmetic shift matches
    quad = (phi + one) >>> (FRAC_BITS + 1);
    z    = phi - quad * 2 * one;
    quad = quad & 3;
    x = shift_floor(r * longint'(CORDIC_GAIN), 16);
    y = 0;
    for (int i = 0; i < ANGLE_ITERATIONS && i < ATAN_LEN; i++) begin
      dx = shift_floor(y, i);
      dy = shift_floor(x, i);
      if (z >= 0) begin
        nx = x - dx; ny = y + dy; z -= atan_step(i);
      end else begin
        nx = x + dx; ny = y - dy; z += atan_step(i);
      end
      x = nx; y = ny;
    end
    case (quad)
      1: begin nx = -y; ny = x;  end
      2: begin nx = -x; ny = -y; end
      3: begin nx = y;  ny = -x; end
      default: begin nx = x; ny = y; end
    endcase
    p.disk_x   = round_sat_q15(nx);
    p.disk_y   = round_sat_q15(ny);
    p.last_out = s.last_sample;
    return p;
  endfunction

  function automatic sample_t make_sample(int u, int v, bit last);
    sample_t s;
    s.u_coord = u[15:0];
    s.v_coord = v[15:0];
    s.last_sample = last;
    return s;
  endfunction

  // Note at the rising edge whether the input word went through.
  always @(posedge clk) begin
    in_taken <= !rst && s_tvalid && s_tready;
  end

  // Driver: drop the head of the queue once accepted, hold an untaken word,
  // otherwise present the next one or idle at the falling edge.
  always @(negedge clk) begin
    sample_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (in_taken) begin
        void'(pending_samples.pop_front());
      end
      if (!s_tvalid || in_taken) begin
        if (pending_samples.size() > 0 && (quiet_phase || $urandom_range(99) >= 25)) begin
          nxt = pending_samples[0];
          s_tvalid <= 1'b1;
          s_tdata  <= {nxt.v_coord, nxt.u_coord};
          s_tlast  <= nxt.last_sample;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= quiet_phase || ($urandom_range(99) >= 25);
  end

  // Predict on input acceptance.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_points.push_back(map_to_disk(make_sample(s_tdata[15:0], s_tdata[31:16], s_tlast)));
    end
  end

  // Monitor: compare each accepted word against the oldest expectation.
  always @(posedge clk) begin
    disk_pt_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected output word x=%h y=%h last=%b", m_tdata[15:0], m_tdata[31:16],
                   m_tlast);
      end else begin
        want = expected_points.pop_front();
        if (m_tdata[15:0] !== want.disk_x || m_tdata[31:16] !== want.disk_y ||
            m_tlast !== want.last_out) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected x=%h y=%h last=%b, got x=%h y=%h last=%b",
                     want.disk_x, want.disk_y, want.last_out,
                     m_tdata[15:0], m_tdata[31:16], m_tlast);
        end
      end
    end
  end

  initial begin
    int u;
    int v;
    int kind;
    mismatch_count = 0;
    stim_done   = 1'b0;
    quiet_phase = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    m_tready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: centre, corners, field extremes, sector boundaries
    pending_samples.push_back(make_sample(32768, 32768, 1'b0));
    pending_samples.push_back(make_sample(0, 0, 1'b1));
    pending_samples.push_back(make_sample(65535, 65535, 1'b0));
    pending_samples.push_back(make_sample(0, 65535, 1'b1));
    pending_samples.push_back(make_sample(65535, 0, 1'b0));
    pending_samples.push_back(make_sample(65535, 32768, 1'b0));
    pending_samples.push_back(make_sample(0, 32768, 1'b0));
    pending_samples.push_back(make_sample(32768, 65535, 1'b0));
    pending_samples.push_back(make_sample(32768, 0, 1'b0));
    pending_samples.push_back(make_sample(40000, 40000, 1'b0));
    pending_samples.push_back(make_sample(20000, 20000, 1'b0));
    pending_samples.push_back(make_sample(40000, 25536, 1'b0));
    pending_samples.push_back(make_sample(25536, 40000, 1'b0));
    pending_samples.push_back(make_sample(32769, 32768, 1'b0));
    pending_samples.push_back(make_sample(32768, 32767, 1'b0));
    pending_samples.push_back(make_sample(32767, 32767, 1'b0));
    pending_samples.push_back(make_sample(50000, 45000, 1'b0));
    pending_samples.push_back(make_sample(45000, 50000, 1'b0));
    pending_samples.push_back(make_sample(15000, 20000, 1'b0));
    pending_samples.push_back(make_sample(20000, 50000, 1'b1));

    // random: uniform mostly, some near the centre and on the diagonals
    for (int n = 0; n < 2000; n++) begin
      kind = $urandom_range(9);
      u = $urandom_range(65535);
      if (kind < 6) v = $urandom_range(65535);
      else if (kind == 6) begin
        u = 32768 + $urandom_range(8) - 4; v = 32768 + $urandom_range(8) - 4;
      end else if (kind == 7) v = u;
      else if (kind == 8) v = 65536 - u;
      else v = (u + $urandom_range(2) - 1) & 16'hffff;
      pending_samples.push_back(make_sample(u, v & 16'hffff, $urandom_range(7) == 0));
      // long stretch with no idling in the middle of the run
      if (n == 800) begin
        wait (pending_samples.size() == 0);
        quiet_phase = 1'b1;
      end
      if (n == 1200) begin
        wait (pending_samples.size() == 0);
        quiet_phase = 1'b0;
      end
    end

    wait (pending_samples.size() == 0);
    wait (expected_points.size() == 0);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/csdm_pkg.sv
rtl/core/concentric_square_to_disk_map.sv
tb/concentric_square_to_disk_map_tb.sv
